@@ hdl/hplp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package hplp_pkg;
	localparam int DATA_WIDTH_DEF = 16;
	localparam int OUT_W = 24;
	localparam int EXP_LAT = 18;
	localparam int LOG_LAT = 18;
	localparam int HEAD_T = 39;
	localparam int GLOG_T = 20;
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam int FRAC_BITS = 12;
	localparam int LOG2_2PI_Q16 = 173768;

	localparam logic [1:0] CH_A = 2'd0;
	localparam logic [1:0] CH_B = 2'd1;
	localparam logic [1:0] MH_NONE = 2'd0;
	localparam logic [1:0] MH_HORIZ = 2'd1;
	localparam logic [1:0] MH_BOTH = 2'd2;

	function automatic logic [63:0] isqrt64(logic [63:0] n);
		logic [63:0] res;
		logic [63:0] rem;
		logic [63:0] b;
		res = '0;
		rem = n;
		for (int i = 0; i < 32; i++) begin
			b = 64'd1 << (62 - 2 * i);
			if (rem >= res + b) begin
				rem = rem - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
		end
		return res;
	endfunction

	// 2^(-2^-(j+1)) in Q.30, truncated square roots
	function automatic logic [30:0] step_c(int j);
		logic [63:0] c;
		c = isqrt64(64'd1 << 59);
		for (int i = 0; i < j; i++) begin
			c = isqrt64(c << 30);
		end
		return c[30:0];
	endfunction

	function automatic int hplp_fin(int dw);
		return (2 + 2 * dw > HEAD_T) ? 2 + 2 * dw : HEAD_T;
	endfunction

	function automatic int hplp_lat(int dw);
		return hplp_fin(dw) + 1;
	endfunction
endpackage
`default_nettype wire

@@ hdl/hplp_delay.sv @@
`timescale 1ns / 1ps
`default_nettype none
module hplp_delay #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  wire logic         clk,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);
	generate
		if (N == 0) begin : g_none
			assign q = d;
		end else begin : g_line
			logic [W-1:0] tap_q [N];
			always_ff @(posedge clk) begin
				tap_q[0] <= d;
				for (int i = 1; i < N; i++) begin
					tap_q[i] <= tap_q[i-1];
				end
			end
			assign q = tap_q[N-1];
		end
	endgenerate
endmodule
`default_nettype wire

@@ hdl/hplp_exp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module hplp_exp import hplp_pkg::*; #(
	parameter int TW = DATA_WIDTH_DEF
) (
	input  wire logic          clk,
	input  wire logic [TW-1:0] t,
	output logic      [30:0]   r
);
	localparam int TXW = (TW > 18) ? TW : 18;

	logic [TXW-1:0] tx;
	logic [47:0]    prod;
	logic [21:0]    u_s    [17];
	logic           zero_s [17];
	logic [30:0]    r_s    [17];
	logic [5:0]     ip;
	logic [30:0]    r_q;

	assign tx   = TXW'(t);
	assign prod = 48'(tx[16:0]) * 48'(LOG2E_Q30);

	always_ff @(posedge clk) begin
		u_s[0]    <= prod[47:26];
		zero_s[0] <= |tx[TXW-1:17];
		r_s[0]    <= ONE_Q30;
	end

	generate
		for (genvar j = 0; j < 16; j++) begin : g_step
			localparam logic [30:0] STEP = step_c(j);
			logic [61:0] p;
			assign p = 62'(r_s[j]) * 62'(STEP);
			always_ff @(posedge clk) begin
				r_s[j+1]    <= u_s[j][15-j] ? p[60:30] : r_s[j];
				u_s[j+1]    <= u_s[j];
				zero_s[j+1] <= zero_s[j];
			end
		end
	endgenerate

	assign ip = u_s[16][21:16];

	always_ff @(posedge clk) begin
		r_q <= (zero_s[16] || ip >= 6'd31) ? '0 : (r_s[16] >> ip);
	end

	assign r = r_q;
endmodule
`default_nettype wire

@@ hdl/hplp_log2.sv @@
`timescale 1ns / 1ps
`default_nettype none
module hplp_log2 import hplp_pkg::*; #(
	parameter int XW = 32,
	parameter int LW = $clog2(XW) + 16
) (
	input  wire logic          clk,
	input  wire logic [XW-1:0] x,
	output logic      [LW-1:0] y
);
	localparam int KW = LW - 16;

	logic [KW-1:0]    k_c;
	logic [KW-1:0]    k_s1;
	logic [XW-1:0]    x_s1;
	logic [XW+29:0]   wide;
	logic [30:0]      m_s [17];
	logic [15:0]      f_s [17];
	logic [KW-1:0]    k_s [17];

	always_comb begin
		k_c = '0;
		for (int i = 0; i < XW; i++) begin
			if (x[i]) k_c = KW'(i);
		end
	end

	assign wide = {x_s1, 30'b0} >> k_s1;

	always_ff @(posedge clk) begin
		k_s1   <= k_c;
		x_s1   <= x;
		m_s[0] <= wide[30:0];
		f_s[0] <= '0;
		k_s[0] <= k_s1;
	end

	generate
		for (genvar i = 0; i < 16; i++) begin : g_sq
			logic [61:0] p;
			logic [31:0] sq;
			assign p  = 62'(m_s[i]) * 62'(m_s[i]);
			assign sq = p[61:30];
			always_ff @(posedge clk) begin
				m_s[i+1] <= sq[31] ? sq[31:1] : sq[30:0];
				f_s[i+1] <= {f_s[i][14:0], sq[31]};
				k_s[i+1] <= k_s[i];
			end
		end
	endgenerate

	assign y = {k_s[16], f_s[16]};
endmodule
`default_nettype wire

@@ hdl/hybrid_policy_log_prob.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Start-to-done delay is set by the head exp/log2 chains or the one-bit-per-stage divider.
// Throughput: one item per cycle; busy is always low.
// done strobes for one cycle with the result; the receiver cannot stall.
// arst_n clears the valid pipeline and sets move_heads to both heads.
module hybrid_policy_log_prob import hplp_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	output logic                              done,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [1:0]                   cfg_data,
	input  wire logic signed [DATA_WIDTH-1:0] horiz_logit_a,
	input  wire logic signed [DATA_WIDTH-1:0] horiz_logit_b,
	input  wire logic signed [DATA_WIDTH-1:0] horiz_logit_c,
	input  wire logic signed [DATA_WIDTH-1:0] vert_logit_a,
	input  wire logic signed [DATA_WIDTH-1:0] vert_logit_b,
	input  wire logic signed [DATA_WIDTH-1:0] vert_logit_c,
	input  wire logic [1:0]                   horiz_choice,
	input  wire logic [1:0]                   vert_choice,
	input  wire logic signed [DATA_WIDTH-1:0] angle_sample,
	input  wire logic signed [DATA_WIDTH-1:0] gauss_mean,
	input  wire logic signed [DATA_WIDTH-1:0] gauss_var_raw,
	output logic signed [OUT_W-1:0]           logp,
	output logic                              saturated
);
	localparam int DW    = DATA_WIDTH;
	localparam int FIN   = hplp_fin(DW);
	localparam int QW    = 2 * DW;
	localparam int DIV_T = 2 + QW;
	localparam int HLW   = $clog2(32) + 16;
	localparam int GLW   = $clog2(DW) + 16;
	localparam int QXW   = (QW > 41) ? QW : 41;
	localparam int TOTW  = 48;
	localparam logic signed [TOTW-1:0] OUT_MAX_W = TOTW'(8388607);
	localparam logic signed [TOTW-1:0] OUT_MIN_W = -TOTW'(8388608);

	logic [1:0]       move_heads_q;
	logic [FIN:0]     vld_q;

	logic signed [DW-1:0] lg [2][3];
	logic [1:0]           ch [2];
	logic signed [DW-1:0] mx_c  [2];
	logic signed [DW-1:0] sel_c [2];
	logic [DW-1:0]        t_s1 [2][3];
	logic signed [DW:0]   seld_s1 [2];

	logic signed [DW:0]   e_c;
	logic signed [DW:0]   ae_c;
	logic signed [DW:0]   v_c;
	logic signed [DW:0]   av_c;
	logic [DW:0]          s_c;
	logic [DW-1:0]        ae_s1;
	logic [DW-1:0]        s_s1;

	logic [30:0]          ex [2][3];
	logic [31:0]          sum_s20 [2];
	logic [HLW-1:0]       hlog [2];
	logic [16:0]          lh_c [2];
	logic [47:0]          lnp_c [2];
	logic [13:0]          lnq_s39 [2];

	logic [GLW-1:0]       glog;
	logic signed [23:0]   gl_c;
	logic [22:0]          gmag_c;
	logic [52:0]          hp_c;
	logic [17:0]          hm_c;
	logic signed [19:0]   half_s20;

	logic [QW-1:0]        num_s [QW];
	logic [DW:0]          den_s [QW];
	logic [DW:0]          rem_s [QW];
	logic [QW-1:0]        quo_s [QW+1];
	logic [QXW-1:0]       qx_c;
	logic [40:0]          qc_c;

	logic [2*(DW+1)-1:0]  seld_d;
	logic [27:0]          lnq_d;
	logic [19:0]          half_d;
	logic [40:0]          q_d;
	logic signed [DW:0]   sd0;
	logic signed [DW:0]   sd1;
	logic signed [19:0]   hf_c;
	logic signed [TOTW-1:0] h0_c;
	logic signed [TOTW-1:0] h1_c;
	logic signed [TOTW-1:0] tot_c;
	logic signed [OUT_W-1:0] logp_q;
	logic                 sat_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_heads_q <= MH_BOTH;
			vld_q        <= '0;
		end else begin
			if (cfg_valid) move_heads_q <= cfg_data;
			vld_q <= {vld_q[FIN-1:0], start};
		end
	end

	assign done = vld_q[FIN];

	// stage 1: max, offsets, chosen logit, gaussian magnitudes
	assign lg[0][0] = horiz_logit_a;
	assign lg[0][1] = horiz_logit_b;
	assign lg[0][2] = horiz_logit_c;
	assign lg[1][0] = vert_logit_a;
	assign lg[1][1] = vert_logit_b;
	assign lg[1][2] = vert_logit_c;
	assign ch[0]    = horiz_choice;
	assign ch[1]    = vert_choice;

	always_comb begin
		for (int h = 0; h < 2; h++) begin
			mx_c[h] = lg[h][0];
			if (lg[h][1] > mx_c[h]) mx_c[h] = lg[h][1];
			if (lg[h][2] > mx_c[h]) mx_c[h] = lg[h][2];
			case (ch[h])
				CH_A:    sel_c[h] = lg[h][0];
				CH_B:    sel_c[h] = lg[h][1];
				default: sel_c[h] = lg[h][2];
			endcase
		end
	end

	assign e_c  = (DW+1)'(angle_sample) - (DW+1)'(gauss_mean);
	assign ae_c = e_c[DW] ? -e_c : e_c;
	assign v_c  = (DW+1)'(gauss_var_raw);
	assign av_c = v_c[DW] ? -v_c : v_c;
	assign s_c  = av_c + (DW+1)'(1);

	always_ff @(posedge clk) begin
		for (int h = 0; h < 2; h++) begin
			for (int i = 0; i < 3; i++) begin
				t_s1[h][i] <= DW'((DW+1)'(mx_c[h]) - (DW+1)'(lg[h][i]));
			end
			seld_s1[h] <= (DW+1)'(sel_c[h]) - (DW+1)'(mx_c[h]);
		end
		ae_s1 <= ae_c[DW-1:0];
		s_s1  <= s_c[DW-1:0];
	end

	// categorical heads: exp, sum, log2, ln
	generate
		for (genvar h = 0; h < 2; h++) begin : g_head
			for (genvar i = 0; i < 3; i++) begin : g_lane
				hplp_exp #(.TW(DW)) u_exp (
					.clk (clk),
					.t   (t_s1[h][i]),
					.r   (ex[h][i])
				);
			end
			hplp_log2 #(.XW(32), .LW(HLW)) u_hlog (
				.clk (clk),
				.x   (sum_s20[h]),
				.y   (hlog[h])
			);
		end
	endgenerate

	always_comb begin
		for (int h = 0; h < 2; h++) begin
			lh_c[h]  = (hlog[h] < HLW'(30 << 16)) ? '0 : 17'(hlog[h] - HLW'(30 << 16));
			lnp_c[h] = 48'(lh_c[h]) * 48'(LN2_Q30) + (48'd1 << 33);
		end
	end

	always_ff @(posedge clk) begin
		for (int h = 0; h < 2; h++) begin
			sum_s20[h] <= 32'(ex[h][0]) + 32'(ex[h][1]) + 32'(ex[h][2]);
			lnq_s39[h] <= lnp_c[h][47:34];
		end
	end

	// gaussian log term
	hplp_log2 #(.XW(DW), .LW(GLW)) u_glog (
		.clk (clk),
		.x   (s_s1),
		.y   (glog)
	);

	assign gl_c   = 24'(glog) - 24'(FRAC_BITS << 16) + 24'(LOG2_2PI_Q16);
	assign gmag_c = gl_c[23] ? 23'(-gl_c) : gl_c[22:0];
	assign hp_c   = 53'(gmag_c) * 53'(LN2_Q30) + (53'd1 << 34);
	assign hm_c   = hp_c[52:35];

	always_ff @(posedge clk) begin
		half_s20 <= gl_c[23] ? -20'(hm_c) : 20'(hm_c);
	end

	// quadratic term: restoring divider, one quotient bit per stage
	always_ff @(posedge clk) begin
		num_s[0] <= QW'(ae_s1) * QW'(ae_s1);
		den_s[0] <= {s_s1, 1'b0};
		rem_s[0] <= '0;
		quo_s[0] <= '0;
	end

	generate
		for (genvar n = 0; n < QW; n++) begin : g_div
			logic [DW+1:0] trial;
			logic          ge;
			assign trial = {rem_s[n], num_s[n][QW-1]};
			assign ge    = trial >= {1'b0, den_s[n]};
			always_ff @(posedge clk) begin
				quo_s[n+1] <= {quo_s[n][QW-2:0], ge};
			end
			if (n < QW - 1) begin : g_carry
				always_ff @(posedge clk) begin
					rem_s[n+1] <= ge ? (DW+1)'(trial - {1'b0, den_s[n]}) : trial[DW:0];
					num_s[n+1] <= num_s[n] << 1;
					den_s[n+1] <= den_s[n];
				end
			end
		end
	endgenerate

	assign qx_c = QXW'(quo_s[QW]);
	assign qc_c = (qx_c > QXW'(64'd1 << 40)) ? (41'd1 << 40) : qx_c[40:0];

	// alignment to the final stage
	hplp_delay #(.W(2*(DW+1)), .N(FIN-1)) u_dly_seld (
		.clk (clk),
		.d   ({seld_s1[1], seld_s1[0]}),
		.q   (seld_d)
	);

	hplp_delay #(.W(28), .N(FIN-HEAD_T)) u_dly_lnq (
		.clk (clk),
		.d   ({lnq_s39[1], lnq_s39[0]}),
		.q   (lnq_d)
	);

	hplp_delay #(.W(20), .N(FIN-GLOG_T)) u_dly_half (
		.clk (clk),
		.d   (half_s20),
		.q   (half_d)
	);

	hplp_delay #(.W(41), .N(FIN-DIV_T)) u_dly_q (
		.clk (clk),
		.d   (qc_c),
		.q   (q_d)
	);

	assign sd0  = $signed(seld_d[DW:0]);
	assign sd1  = $signed(seld_d[2*DW+1:DW+1]);
	assign hf_c = $signed(half_d);
	assign h0_c = TOTW'(sd0) - TOTW'(lnq_d[13:0]);
	assign h1_c = TOTW'(sd1) - TOTW'(lnq_d[27:14]);

	always_comb begin
		tot_c = -TOTW'(hf_c) - TOTW'(q_d);
		if (move_heads_q >= MH_HORIZ) tot_c = tot_c + h0_c;
		if (move_heads_q >= MH_BOTH)  tot_c = tot_c + h1_c;
	end

	always_ff @(posedge clk) begin
		if (tot_c > OUT_MAX_W) begin
			logp_q <= OUT_MAX_W[OUT_W-1:0];
			sat_q  <= 1'b1;
		end else if (tot_c < OUT_MIN_W) begin
			logp_q <= OUT_MIN_W[OUT_W-1:0];
			sat_q  <= 1'b1;
		end else begin
			logp_q <= tot_c[OUT_W-1:0];
			sat_q  <= 1'b0;
		end
	end

	assign logp      = logp_q;
	assign saturated = sat_q;
endmodule
`default_nettype wire

@@ hdl/hplp_check.sv @@
`timescale 1ns / 1ps
`default_nettype none
module hplp_check import hplp_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    start,
	input wire logic                    busy,
	input wire logic                    done,
	input wire logic signed [OUT_W-1:0] logp,
	input wire logic                    saturated
);
	localparam int LAT = hplp_lat(DATA_WIDTH);

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("item accepted without its result");

	a_result_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without an accepted item");

	a_sat_clipped: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |-> (logp == 24'h7fffff || logp == 24'h800000))
		else $error("saturated flag on an unclipped value");

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("block refused an item");
endmodule

bind hybrid_policy_log_prob hplp_check #(.DATA_WIDTH(DATA_WIDTH)) u_hplp_check (.*);
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
module tb;
	import hplp_pkg::*;

	localparam int DW = 16;
	localparam int LAT = 40;
	localparam int LIMIT = 200000;

	typedef enum logic [1:0] {K_ITEM, K_CFG, K_DRAIN} kind_t;

	typedef struct {
		kind_t kind;
		logic [1:0] heads;
		logic signed [DW-1:0] ha, hb, hc, va, vb, vc;
		logic [1:0] hch, vch;
		logic signed [DW-1:0] ang, mu, var_raw;
	} item_t;

	typedef struct {
		logic signed [OUT_W-1:0] lp;
		logic sat;
	} lp_res_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic cfg_valid = 0;
	logic [1:0] cfg_data = '0;
	item_t cur;
	wire busy, done, cfg_ready, saturated;
	wire signed [OUT_W-1:0] logp;

	item_t pend_q[$];
	lp_res_t lp_expect_q[$];
	logic [63:0] step_tab[16];
	logic [1:0] heads_cfg = MH_BOTH;
	int errors = 0;
	int cyc = 0;
	int gap = 0;
	int burst = 4;
	int quiet = 0;

	hybrid_policy_log_prob u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.horiz_logit_a(cur.ha), .horiz_logit_b(cur.hb), .horiz_logit_c(cur.hc),
		.vert_logit_a(cur.va), .vert_logit_b(cur.vb), .vert_logit_c(cur.vc),
		.horiz_choice(cur.hch), .vert_choice(cur.vch),
		.angle_sample(cur.ang), .gauss_mean(cur.mu), .gauss_var_raw(cur.var_raw),
		.logp(logp), .saturated(saturated)
	);

	initial forever #6 clk = ~clk;

	function automatic logic [63:0] int_sqrt(logic [63:0] n);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// exp of d <= 0, Q.12 in, Q.30 out
	function automatic logic [63:0] exp_q30(longint d);
		logic [63:0] t, u, r, ip;
		if (d >= 0) return 64'd1 << 30;
		t = -d;
		if (t >= (64'd1 << 17)) return 0;
		u = (t * 64'd1549082005) >> 26;
		r = 64'd1 << 30;
		for (int j = 0; j < 16; j++)
			if (u[15-j]) r = (r * step_tab[j]) >> 30;
		ip = u >> 16;
		if (ip >= 31) return 0;
		return r >> ip;
	endfunction

	function automatic longint log2_q16(logic [63:0] x);
		int k;
		logic [63:0] m, frac;
		k = 63;
		frac = 0;
		if (x == 0) x = 1;
		while (x[k] == 1'b0) k--;
		m = (k > 30) ? (x >> (k - 30)) : (x << (30 - k));
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac[0] = 1'b1;
			end
		end
		return longint'(k) * 65536 + longint'(frac);
	endfunction

	function automatic longint head_lp(longint a, longint b, longint c, logic [1:0] ch);
		longint mx, sel, l2, lnq;
		logic [63:0] s;
		mx = a;
		if (b > mx) mx = b;
		if (c > mx) mx = c;
		s = exp_q30(a - mx) + exp_q30(b - mx) + exp_q30(c - mx);
		l2 = log2_q16(s) - 30 * 65536;
		if (l2 < 0) l2 = 0;
		lnq = longint'((64'(l2) * 64'd744261118 + (64'd1 << 33)) >> 34);
		sel = (ch == CH_A) ? a : ((ch == CH_B) ? b : c);
		return (sel - mx) - lnq;
	endfunction

	function automatic lp_res_t predict_result(item_t it, logic [1:0] heads);
		longint total, x, m, v, l, half, e, ae, q;
		logic [63:0] s;
		lp_res_t r;
		total = 0;
		if (heads >= MH_HORIZ) total += head_lp(it.ha, it.hb, it.hc, it.hch);
		if (heads >= MH_BOTH) total += head_lp(it.va, it.vb, it.vc, it.vch);
		x = it.ang;
		m = it.mu;
		v = it.var_raw;
		s = (v < 0 ? -v : v) + 1;
		l = log2_q16(s) - 12 * 65536 + 173768;
		l = l * 744261118;
		if (l < 0) half = -longint'((64'(-l) + (64'd1 << 34)) >> 35);
		else half = longint'((64'(l) + (64'd1 << 34)) >> 35);
		e = x - m;
		ae = e < 0 ? -e : e;
		q = longint'(64'(ae * ae) / (2 * s));
		if (q > (longint'(1) << 40)) q = longint'(1) << 40;
		total = total - half - q;
		r.sat = 0;
		if (total > 8388607) begin
			total = 8388607;
			r.sat = 1;
		end
		if (total < -8388608) begin
			total = -8388608;
			r.sat = 1;
		end
		r.lp = total[OUT_W-1:0];
		return r;
	endfunction

	function automatic logic [15:0] rnd_val(int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 1023) - 512);
			2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			default: return 16'($urandom_range(0, 16383) - 8192);
		endcase
	endfunction

	function automatic item_t rnd_item();
		item_t it;
		int lm, gm;
		lm = $urandom_range(0, 3);
		gm = $urandom_range(0, 9) < 6 ? 1 : $urandom_range(0, 3);
		it.kind = K_ITEM;
		it.heads = 0;
		it.ha = rnd_val(lm); it.hb = rnd_val(lm); it.hc = rnd_val(lm);
		it.va = rnd_val(lm); it.vb = rnd_val(lm); it.vc = rnd_val(lm);
		it.hch = 2'($urandom); it.vch = 2'($urandom);
		it.ang = rnd_val(gm); it.mu = rnd_val(gm);
		it.var_raw = $urandom_range(0, 1) ? rnd_val(0) : 16'($urandom_range(0, 8191));
		return it;
	endfunction

	function automatic item_t mk(logic [15:0] a, logic [15:0] b, logic [15:0] c,
			logic [1:0] ch, logic [15:0] ang, logic [15:0] mu, logic [15:0] vr);
		item_t it;
		it.kind = K_ITEM;
		it.heads = 0;
		it.ha = a; it.hb = b; it.hc = c;
		it.va = c; it.vb = a; it.vc = b;
		it.hch = ch; it.vch = ~ch;
		it.ang = ang; it.mu = mu; it.var_raw = vr;
		return it;
	endfunction

	function automatic item_t ctl(kind_t k, logic [1:0] h);
		item_t it;
		it = mk(0, 0, 0, 0, 0, 0, 0);
		it.kind = k;
		it.heads = h;
		return it;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cyc);
		errors++;
	endtask

	// driver
	always @(posedge clk) begin
		logic n_start, n_cfgv;
		logic [1:0] n_cfgd;
		item_t n_cur, e;
		n_start = 0;
		n_cfgv = 0;
		n_cfgd = cfg_data;
		n_cur = cur;
		if (arst_n) begin
			if (start && !busy) lp_expect_q.push_back(predict_result(cur, heads_cfg));
			if (cfg_valid && cfg_ready) heads_cfg = cfg_data;
			quiet = (lp_expect_q.size() == 0) ? quiet + 1 : 0;
			if (start && busy) begin
				n_start = 1;
			end else if (cfg_valid && !cfg_ready) begin
				n_cfgv = 1;
			end else if (gap > 0) begin
				gap--;
			end else if (pend_q.size() > 0 && !(cfg_valid && cfg_ready)) begin
				e = pend_q[0];
				if (e.kind == K_ITEM) begin
					void'(pend_q.pop_front());
					n_cur = e;
					n_start = 1;
					burst--;
					if (burst <= 0) begin
						burst = $urandom_range(1, 16);
						gap = $urandom_range(0, 9) < 2 ? 0 : $urandom_range(1, 12);
					end
				end else if (!start && quiet >= 4) begin
					void'(pend_q.pop_front());
					if (e.kind == K_CFG) begin
						n_cfgv = 1;
						n_cfgd = e.heads;
					end
				end
			end
		end
		start <= n_start;
		cfg_valid <= n_cfgv;
		cfg_data <= n_cfgd;
		cur <= n_cur;
	end

	// monitor
	always @(posedge clk) begin
		lp_res_t w;
		if (arst_n && done) begin
			if (lp_expect_q.size() == 0) begin
				report("unexpected item", logp, 0);
			end else begin
				w = lp_expect_q.pop_front();
				if (logp !== w.lp) report("logp", logp, w.lp);
				if (saturated !== w.sat) report("saturated", saturated, w.sat);
			end
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc > LIMIT) begin
			$display("hybrid_policy_log_prob verification failed");
			$finish;
		end
	end

	initial begin
		logic [1:0] settings[5];
		settings = '{MH_BOTH, MH_NONE, MH_HORIZ, 2'd3, MH_BOTH};
		cur = mk(0, 0, 0, 0, 0, 0, 0);
		step_tab[0] = int_sqrt(64'd1 << 59);
		for (int j = 1; j < 16; j++) step_tab[j] = int_sqrt(step_tab[j-1] << 30);

		// directed: logit extremes, all choices, variance edge cases
		pend_q.push_back(mk(16'h7fff, 16'h8000, 16'h0000, 0, 0, 0, 16'h1000));
		pend_q.push_back(mk(16'h7fff, 16'h8000, 16'h0000, 1, 0, 0, 16'h1000));
		pend_q.push_back(mk(16'h7fff, 16'h8000, 16'h0000, 2, 0, 0, 16'h1000));
		pend_q.push_back(mk(16'h7fff, 16'h8000, 16'h0000, 3, 0, 0, 16'h1000));
		pend_q.push_back(mk(0, 0, 0, 0, 0, 0, 16'h1000));
		pend_q.push_back(mk(16'h8000, 16'h8000, 16'h8000, 3, 0, 0, 16'h1000));
		pend_q.push_back(mk(16'hffff, 16'hffff, 16'hffff, 2, 0, 0, 16'hffff));
		pend_q.push_back(mk(0, 16'h0001, 16'h0002, 1, 16'h7fff, 16'h8000, 16'h0000));
		pend_q.push_back(mk(0, 0, 0, 0, 16'h8000, 16'h7fff, 16'h8000));
		pend_q.push_back(mk(0, 0, 0, 0, 16'h7fff, 16'h8000, 16'h7fff));
		pend_q.push_back(mk(0, 0, 0, 0, 16'h0005, 16'h0005, 16'h0000));
		pend_q.push_back(mk(0, 0, 0, 0, 16'h0001, 16'h0000, 16'h0000));
		pend_q.push_back(mk(16'h1000, 0, 16'hf000, 2, 16'h1000, 0, 16'hf000));
		pend_q.push_back(mk(16'h5555, 16'haaaa, 16'h5555, 0, 16'haaaa, 16'h5555, 16'haaaa));
		for (int p = 0; p < 5; p++) begin
			if (p > 0) pend_q.push_back(ctl(K_CFG, settings[p]));
			if (p == 2) pend_q.push_back(mk(16'h7fff, 16'h7fff, 16'h8000, 3, 0, 0, 0));
			for (int i = 0; i < 100; i++) begin
				pend_q.push_back(rnd_item());
				if (i == 50) pend_q.push_back(ctl(K_DRAIN, 0));
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1;
		wait (pend_q.size() == 0);
		do @(posedge clk); while (start || cfg_valid || lp_expect_q.size() != 0);
		repeat (LAT + 5) @(posedge clk);
		if (errors == 0 && lp_expect_q.size() == 0) begin
			$display("hybrid_policy_log_prob verification clean");
		end else begin
			$display("hybrid_policy_log_prob verification failed");
		end
		$finish;
	end
endmodule
